// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL files of the bit packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a trigger implies a condition in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

`endif

// ----- sv/lbp_pkg.sv -----
`timescale 1ns / 1ps

package lbp_pkg;

    localparam int VALUE_W   = 32;
    localparam int WIDTH_W   = 6;
    localparam int BYTE_W    = 8;
    localparam int PEND_W    = 7;
    localparam int PCNT_W    = 3;
    localparam int MAX_WIDTH = 32;
    // Effective width limit: the value port carries only 32 bits.
    localparam int WIDTH_LIM = (MAX_WIDTH < VALUE_W) ? MAX_WIDTH : VALUE_W;
    // Pending bits plus a full value, rounded up to whole bytes.
    localparam int ACC_W     = 40;
    localparam int TOTAL_W   = 6;
    localparam int NB_W      = 3;
    localparam int MAX_BYTES = 5;

    // One queued job: the bytes of one item and how many of them to send.
    typedef struct packed {
        logic [ACC_W-1:0] data;
        logic [NB_W-1:0]  nbytes;
    } t_entry;

endpackage

// ----- sv/lsb_first_bit_packer_core.sv -----
`timescale 1ns / 1ps

// LSB-first bit packer. Each word pushed carries a value, a width from 0 to 32
// (larger widths are treated as 32) and a flush flag; the low bits of the value
// are appended above the bits still pending, and every completed byte comes out
// on the result side lowest byte first, with o_last marking the final byte a
// word produced. With flush set, a remaining partial byte is sent padded with
// zeros above and the pending bits are cleared. A word that completes no byte
// produces no result. The front end accepts one word per cycle while the job
// queue (QUEUE_DEPTH entries) has room; the back end sends one byte per cycle
// while pop is asserted, so a word producing k bytes needs k pops (one to four,
// five with a flush), and that byte port sets the sustained rate. A word's
// bytes are written into the job queue and then loaded into the back end's
// register before they appear on the result ports.
module lsb_first_bit_packer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [lbp_pkg::VALUE_W-1:0]  i_field_value,
    input  logic [lbp_pkg::WIDTH_W-1:0]  i_field_width,
    input  logic                         i_flush,
    output logic                         empty,
    input  logic                         pop,
    output logic [lbp_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_last
);

    logic            w_accept;
    logic            w_q_push;
    lbp_pkg::t_entry w_q_in;
    lbp_pkg::t_entry w_q_head;
    logic            w_q_pop;
    logic            w_q_empty;

    // A word is taken whenever the job queue has room.
    assign w_accept = push && !full;

    // The front end merges the word with the pending bits and works out how
    // many bytes it completes.
    lbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_field_value (i_field_value),
        .i_field_width (i_field_width),
        .i_flush       (i_flush),
        .o_push        (w_q_push),
        .o_entry       (w_q_in)
    );

    // The queue decouples word intake from byte delivery.
    lbp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_q_in),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    // The back end holds the current job and shifts out one byte per pop.
    lbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_q_head),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .pop        (pop),
        .empty      (empty),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

// ----- sv/lbp_front.sv -----
`timescale 1ns / 1ps

module lbp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [lbp_pkg::VALUE_W-1:0]   i_field_value,
    input  logic [lbp_pkg::WIDTH_W-1:0]   i_field_width,
    input  logic                          i_flush,
    output logic                          o_push,
    output lbp_pkg::t_entry               o_entry
);

    logic [lbp_pkg::PEND_W-1:0]  r_pend_bits, n_pend_bits;
    logic [lbp_pkg::PCNT_W-1:0]  r_pend_cnt, n_pend_cnt;
    logic [lbp_pkg::WIDTH_W-1:0] w_width;
    logic [lbp_pkg::VALUE_W-1:0] w_masked;
    logic [lbp_pkg::ACC_W-1:0]   w_acc;
    logic [lbp_pkg::ACC_W-1:0]   w_rest;
    logic [lbp_pkg::TOTAL_W-1:0] w_total;
    logic [lbp_pkg::NB_W-1:0]    w_nfull;
    logic [lbp_pkg::NB_W-1:0]    w_nbytes;
    logic                        w_partial;

    always_comb begin
        if (i_field_width > lbp_pkg::WIDTH_W'(lbp_pkg::WIDTH_LIM)) begin
            w_width = lbp_pkg::WIDTH_W'(lbp_pkg::WIDTH_LIM);
        end else begin
            w_width = i_field_width;
        end
        // A shift by the full width leaves zero, so the mask becomes all ones.
        w_masked  = i_field_value & ~({lbp_pkg::VALUE_W{1'b1}} << w_width);
        w_acc     = {{(lbp_pkg::ACC_W - lbp_pkg::PEND_W){1'b0}}, r_pend_bits}
                  | ({{(lbp_pkg::ACC_W - lbp_pkg::VALUE_W){1'b0}}, w_masked} << r_pend_cnt);
        w_total   = lbp_pkg::TOTAL_W'(r_pend_cnt) + w_width;
        w_nfull   = w_total[lbp_pkg::TOTAL_W-1:3];
        w_partial = i_flush && (w_total[2:0] != 3'd0);
        w_nbytes  = w_nfull + lbp_pkg::NB_W'(w_partial);
        w_rest    = w_acc >> {w_nfull, 3'b000};
        if (i_flush) begin
            n_pend_bits = '0;
            n_pend_cnt  = '0;
        end else begin
            n_pend_bits = w_rest[lbp_pkg::PEND_W-1:0];
            n_pend_cnt  = w_total[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else if (i_accept) begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    // Items that complete no byte only update the pending bits.
    assign o_push         = i_accept && (w_nbytes != '0);
    assign o_entry.data   = w_acc;
    assign o_entry.nbytes = w_nbytes;

endmodule

// ----- sv/lbp_fifo.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbp_pkg::t_entry i_entry,
    input  logic            i_pop,
    output lbp_pkg::t_entry o_head,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lbp_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "queue written while full")
    `ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "queue read while empty")

endmodule

// ----- sv/lbp_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lbp_pkg::t_entry              i_head,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [lbp_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_last
);

    logic [lbp_pkg::ACC_W-1:0] r_data;
    logic [lbp_pkg::NB_W-1:0]  r_left;
    logic                      w_take;
    logic                      w_load;

    assign w_take  = pop && (r_left != '0);
    // Load the next job when idle or as the final byte of this one leaves.
    assign w_load  = !i_q_empty && ((r_left == '0) || (w_take && (r_left == 3'd1)));
    assign o_q_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (w_load) begin
            r_left <= i_head.nbytes;
        end else if (w_take) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_head.data;
        end else if (w_take) begin
            r_data <= r_data >> lbp_pkg::BYTE_W;
        end
    end

    assign empty      = (r_left == '0);
    assign o_out_byte = r_data[lbp_pkg::BYTE_W-1:0];
    assign o_last     = (r_left == 3'd1);

    `ASSERT_IMPL(a_job_nonzero, i_clk, i_rst_n, w_load, i_head.nbytes != '0, "empty job queued")
    `ASSERT_CLK(a_left_range, i_clk, i_rst_n, r_left <= 3'(lbp_pkg::MAX_BYTES), "byte count too large")

endmodule
